// ===== sv/zero_run_magnitude_encoder_top_defines.svh =====
// Assertion macros used by the checker of this block.
`ifndef ZERO_RUN_MAGNITUDE_ENCODER_TOP_DEFINES_SVH
`define ZERO_RUN_MAGNITUDE_ENCODER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZRME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZRME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/zrme_pkg.sv =====
package zrme_pkg;

    localparam int COEF_BITS = 16;
    localparam int RUN_BITS  = 7;
    localparam int ZRUN_BITS = 6;
    localparam int CAT_BITS  = 4;
    localparam int AMP_BITS  = 15;

    localparam logic [RUN_BITS-1:0]  RUN_MAX  = '1;
    localparam logic [ZRUN_BITS-1:0] ZRUN_MAX = '1;
    localparam logic [AMP_BITS-1:0]  AMP_MAX  = '1;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] coef_value;
        logic                        block_end;
    } coef_item_t;

    typedef struct packed {
        logic [ZRUN_BITS-1:0] zero_run;
        logic [CAT_BITS-1:0]  size_category;
        logic [AMP_BITS-1:0]  amplitude_bits;
        logic                 end_mark;
    } pair_item_t;

    // What the classifier tells the run tracker about one coefficient.
    typedef struct packed {
        logic                is_zero;
        logic [CAT_BITS-1:0] size_category;
        logic [AMP_BITS-1:0] amplitude_bits;
    } coef_info_t;

endpackage

// ===== sv/zero_run_magnitude_encoder_top.sv =====
// Zero-run / magnitude-category encoder. Takes one signed coefficient per transfer on the
// coef channel and returns at most one (run, category, amplitude, end) pair on the pair
// channel. Zeros inside a block are only counted; a nonzero value or the block's last
// coefficient produces a pair. Throughput is one coefficient per clock unless coef_stall holds
// the input. The coefficient is first held in the input register, then its pair is written
// into the result register once that register has space. The
// classification and run update sit in one combinational stage between those registers.
// coef_stall follows pair_stall combinationally while the result register is full and the
// held coefficient yields a pair; a coefficient that yields no pair never stalls.
module zero_run_magnitude_encoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 coef_valid,
    output logic                 coef_stall,
    input  zrme_pkg::coef_item_t coef,
    output logic                 pair_valid,
    input  logic                 pair_stall,
    output zrme_pkg::pair_item_t pair
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    zrme_pkg::coef_item_t s1_item_reg;
    zrme_pkg::coef_info_t info;
    zrme_pkg::pair_item_t emit_pair;
    logic                 emit;
    logic                 space;
    logic                 s1_fire;

    // A coefficient that yields no pair never waits for the result register.
    assign s1_fire    = s1_valid_reg && (!emit || space);
    assign coef_stall = s1_valid_reg && !s1_fire;

    assign s1_valid_next = coef_stall ? s1_valid_reg : coef_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_valid && !coef_stall)
        begin
            s1_item_reg <= coef;
        end
    end

    zrme_coef_classify u_classify (
        .coef_value (s1_item_reg.coef_value),
        .info       (info)
    );

    zrme_run_tracker u_run_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_fire),
        .block_end (s1_item_reg.block_end),
        .info      (info),
        .emit      (emit),
        .pair      (emit_pair)
    );

    zrme_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (s1_valid_reg && emit),
        .emit_pair  (emit_pair),
        .space      (space),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair       (pair)
    );

endmodule

// ===== sv/zrme_coef_classify.sv =====
module zrme_coef_classify (
    input  logic signed [zrme_pkg::COEF_BITS-1:0] coef_value,
    output zrme_pkg::coef_info_t                  info
);

    logic                              neg;
    logic [zrme_pkg::COEF_BITS-1:0]    mag_full;
    logic [zrme_pkg::AMP_BITS-1:0]     mag;
    logic [zrme_pkg::CAT_BITS-1:0]     cat;
    logic [zrme_pkg::COEF_BITS-1:0]    mask_full;

    assign neg      = coef_value[zrme_pkg::COEF_BITS-1];
    assign mag_full = neg ? (~coef_value + 1'b1) : coef_value;

    // Only the most negative value leaves the top bit set; it saturates.
    assign mag = mag_full[zrme_pkg::COEF_BITS-1] ? zrme_pkg::AMP_MAX
                                                  : mag_full[zrme_pkg::AMP_BITS-1:0];

    always_comb
    begin
        cat = '0;
        for (int i = 0; i < zrme_pkg::AMP_BITS; i++)
        begin
            if (mag[i])
            begin
                cat = zrme_pkg::CAT_BITS'(i + 1);
            end
        end
    end

    assign mask_full = (zrme_pkg::COEF_BITS'(1) << cat) - zrme_pkg::COEF_BITS'(1);

    assign info.is_zero        = (mag == '0);
    assign info.size_category  = cat;
    assign info.amplitude_bits = neg ? (~mag & mask_full[zrme_pkg::AMP_BITS-1:0]) : mag;

endmodule

// ===== sv/zrme_run_tracker.sv =====
module zrme_run_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 block_end,
    input  zrme_pkg::coef_info_t info,
    output logic                 emit,
    output zrme_pkg::pair_item_t pair
);

    logic [zrme_pkg::RUN_BITS-1:0] run_count_reg;
    logic [zrme_pkg::RUN_BITS-1:0] run_count_next;
    logic [zrme_pkg::RUN_BITS-1:0] count_inc;
    logic [zrme_pkg::RUN_BITS-1:0] run_value;

    function automatic logic [zrme_pkg::ZRUN_BITS-1:0] clip_run(
        input logic [zrme_pkg::RUN_BITS-1:0] r
    );
        if (r > zrme_pkg::RUN_BITS'(zrme_pkg::ZRUN_MAX))
        begin
            return zrme_pkg::ZRUN_MAX;
        end
        return r[zrme_pkg::ZRUN_BITS-1:0];
    endfunction

    assign count_inc = (run_count_reg == zrme_pkg::RUN_MAX) ? run_count_reg
                                                            : run_count_reg + 1'b1;

    // A zero emits only when it closes the block; its own count is included.
    assign emit      = info.is_zero ? block_end : 1'b1;
    assign run_value = info.is_zero ? (count_inc - 1'b1) : run_count_reg;

    assign pair.zero_run       = clip_run(run_value);
    assign pair.size_category  = info.is_zero ? '0 : info.size_category;
    assign pair.amplitude_bits = info.is_zero ? '0 : info.amplitude_bits;
    assign pair.end_mark       = block_end;

    always_comb
    begin
        run_count_next = run_count_reg;
        if (fire)
        begin
            run_count_next = emit ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= '0;
        end
        else
        begin
            run_count_reg <= run_count_next;
        end
    end

endmodule

// ===== sv/zrme_out_stage.sv =====
module zrme_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 emit,
    input  zrme_pkg::pair_item_t emit_pair,
    output logic                 space,
    output logic                 pair_valid,
    input  logic                 pair_stall,
    output zrme_pkg::pair_item_t pair
);

    logic                 valid_reg;
    logic                 valid_next;
    zrme_pkg::pair_item_t pair_reg;

    // The register can take a new pair when empty or when its pair transfers now.
    assign space      = !valid_reg || !pair_stall;
    assign valid_next = space ? emit : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && space)
        begin
            pair_reg <= emit_pair;
        end
    end

    assign pair_valid = valid_reg;
    assign pair       = pair_reg;

endmodule

// ===== sv/zrme_checker.sv =====
`include "zero_run_magnitude_encoder_top_defines.svh"

module zrme_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 coef_valid,
    input logic                 coef_stall,
    input zrme_pkg::coef_item_t coef,
    input logic                 pair_valid,
    input logic                 pair_stall,
    input zrme_pkg::pair_item_t pair
);

    `ZRME_ASSERT_NEXT(a_pair_hold, clk, rst_n, pair_valid && pair_stall,
        pair_valid && $stable(pair), "stalled pair changed or dropped")

    `ZRME_ASSERT_NEXT(a_coef_hold, clk, rst_n, coef_valid && coef_stall,
        coef_valid && $stable(coef), "stalled coefficient changed or dropped")

    `ZRME_ASSERT_NOW(a_trailing_pair, clk, rst_n, pair_valid && (pair.size_category == '0),
        (pair.amplitude_bits == '0) && pair.end_mark,
        "category zero pair is not a block end pair")

    `ZRME_ASSERT_NOW(a_amp_fits, clk, rst_n, pair_valid,
        (pair.amplitude_bits >> pair.size_category) == '0,
        "amplitude wider than its category")

    // The input only stalls behind a full, stalled result register.
    `ZRME_ASSERT_NOW(a_stall_cause, clk, rst_n, coef_stall,
        pair_valid && pair_stall, "coefficient stalled while the pair side was free")

endmodule

bind zero_run_magnitude_encoder_top zrme_checker u_checker (.*);

// ===== test/zero_run_pair_checker.sv =====
`timescale 1ns / 1ps

module zero_run_pair_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 coef_valid,
    input  logic                 coef_stall,
    input  zrme_pkg::coef_item_t coef,
    input  logic                 pair_valid,
    input  logic                 pair_stall,
    input  zrme_pkg::pair_item_t pair,
    output int                   mismatch_count,
    output int                   pairs_owed
);

    zrme_pkg::pair_item_t expected_pairs[$];
    zrme_pkg::pair_item_t predicted;
    zrme_pkg::pair_item_t oldest;
    logic [zrme_pkg::RUN_BITS-1:0] zeros_seen;

    function automatic logic [zrme_pkg::ZRUN_BITS-1:0] clip_run(
        input logic [zrme_pkg::RUN_BITS-1:0] run
    );
        if (run > zrme_pkg::RUN_BITS'(zrme_pkg::ZRUN_MAX))
            return zrme_pkg::ZRUN_MAX;
        return run[zrme_pkg::ZRUN_BITS-1:0];
    endfunction

    // Updates the zero count and returns 1 when the coefficient produces a pair.
    function automatic bit encode_coef(
        input  zrme_pkg::coef_item_t c,
        output zrme_pkg::pair_item_t p
    );
        logic [zrme_pkg::COEF_BITS:0]  wide_mag;
        logic [zrme_pkg::AMP_BITS-1:0] mag;
        logic [zrme_pkg::AMP_BITS-1:0] cat_mask;
        logic                          neg;
        int                            cat;
        neg = c.coef_value[zrme_pkg::COEF_BITS-1];
        if (neg)
            wide_mag = (17'd1 << zrme_pkg::COEF_BITS) - {1'b0, c.coef_value};
        else
            wide_mag = {1'b0, c.coef_value};
        // The most negative input has no positive twin; its magnitude saturates.
        if (wide_mag > {2'b00, zrme_pkg::AMP_MAX})
            mag = zrme_pkg::AMP_MAX;
        else
            mag = wide_mag[zrme_pkg::AMP_BITS-1:0];
        p = '0;
        if (mag == '0)
        begin
            if (zeros_seen != zrme_pkg::RUN_MAX)
                zeros_seen = zeros_seen + 1'b1;
            if (!c.block_end)
                return 1'b0;
            p.zero_run = clip_run(zeros_seen - 1'b1);
            p.end_mark = 1'b1;
            zeros_seen = '0;
            return 1'b1;
        end
        cat = 0;
        for (int i = 0; i < zrme_pkg::AMP_BITS; i++)
            if (mag[i])
                cat = i + 1;
        cat_mask = zrme_pkg::AMP_BITS'((32'd1 << cat) - 1);
        p.zero_run = clip_run(zeros_seen);
        p.size_category = zrme_pkg::CAT_BITS'(cat);
        p.amplitude_bits = neg ? (cat_mask ^ mag) : mag;
        p.end_mark = c.block_end;
        zeros_seen = '0;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pairs.delete();
            zeros_seen = '0;
            pairs_owed <= 0;
        end
        else
        begin
            if (pair_valid && !pair_stall)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $error("pair transfer with no pair expected: %p", pair);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_pairs.pop_front();
                    if (pair.zero_run !== oldest.zero_run)
                    begin
                        $error("zero_run: expected %0d, actual %0d",
                               oldest.zero_run, pair.zero_run);
                        mismatch_count++;
                    end
                    if (pair.size_category !== oldest.size_category)
                    begin
                        $error("size_category: expected %0d, actual %0d",
                               oldest.size_category, pair.size_category);
                        mismatch_count++;
                    end
                    if (pair.amplitude_bits !== oldest.amplitude_bits)
                    begin
                        $error("amplitude_bits: expected %0d, actual %0d",
                               oldest.amplitude_bits, pair.amplitude_bits);
                        mismatch_count++;
                    end
                    if (pair.end_mark !== oldest.end_mark)
                    begin
                        $error("end_mark: expected %0d, actual %0d",
                               oldest.end_mark, pair.end_mark);
                        mismatch_count++;
                    end
                end
            end
            if (coef_valid && !coef_stall)
                if (encode_coef(coef, predicted))
                    expected_pairs.insert(expected_pairs.size(), predicted);
            pairs_owed <= expected_pairs.size();
        end
    end

endmodule

// ===== test/tb_zero_run_magnitude_encoder_top.sv =====
`timescale 1ns / 1ps

module tb_zero_run_magnitude_encoder_top;

    localparam int HOLD_CYCLES = 200;
    localparam int LIMIT_CYCLES = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 coef_valid;
    logic                 coef_stall;
    zrme_pkg::coef_item_t coef;
    logic                 pair_valid;
    logic                 pair_stall = 1'b0;
    zrme_pkg::pair_item_t pair;

    int mismatch_count;
    int pairs_owed;
    int coefs_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    event hold_start;
    bit hold_pair = 1'b0;

    zero_run_magnitude_encoder_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coef       (coef),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair       (pair)
    );

    zero_run_pair_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .coef_valid     (coef_valid),
        .coef_stall     (coef_stall),
        .coef           (coef),
        .pair_valid     (pair_valid),
        .pair_stall     (pair_stall),
        .pair           (pair),
        .mismatch_count (mismatch_count),
        .pairs_owed     (pairs_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_pair)
            pair_stall <= 1'b1;
        else
            pair_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Long receiver hold-off, so the block fills up and stalls its input.
    initial
    begin
        forever
        begin
            @(hold_start);
            hold_pair <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_pair <= 1'b0;
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic zrme_pkg::coef_item_t make_coef(input int value, input bit last);
        zrme_pkg::coef_item_t item;
        item.coef_value = zrme_pkg::COEF_BITS'(value);
        item.block_end = last;
        return item;
    endfunction

    function automatic zrme_pkg::coef_item_t random_coef(input bit last);
        int cat;
        int mag;
        if ($urandom_range(0, 99) < 55)
            return make_coef(0, last);
        if ($urandom_range(0, 39) == 0)
            return make_coef(-32768, last);
        cat = $urandom_range(1, 15);
        mag = $urandom_range(1 << (cat - 1), (1 << cat) - 1);
        return make_coef($urandom_range(0, 1) ? -mag : mag, last);
    endfunction

    task automatic send_coef(input zrme_pkg::coef_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            coef_valid <= 1'b0;
            @(posedge clk);
        end
        coef_valid <= 1'b1;
        coef <= item;
        @(posedge clk);
        while (coef_stall)
            @(posedge clk);
        coefs_sent++;
    endtask

    task automatic drain_pairs();
        coef_valid <= 1'b0;
        @(posedge clk);
        while (pairs_owed != 0)
            @(posedge clk);
    endtask

    task automatic send_block(input int len, input int lead_zeros);
        for (int i = 0; i < lead_zeros; i++)
            send_coef(make_coef(0, 1'b0));
        for (int i = 0; i < len; i++)
            send_coef(random_coef(i == len - 1));
    endtask

    task automatic run_blocks(input int upto);
        int pick;
        while (coefs_sent < upto)
        begin
            pick = $urandom_range(0, 23);
            // A long zero run can push the run counter past both saturation points.
            if (pick == 0)
                send_block($urandom_range(1, 8), $urandom_range(60, 150));
            else if (pick == 1)
                send_block(64, 0);
            else
                send_block($urandom_range(1, 16), 0);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        coef_valid <= 1'b0;
        coef <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct <= 53;

        send_coef(make_coef(1, 1'b0));
        send_coef(make_coef(-1, 1'b0));
        send_coef(make_coef(32767, 1'b0));
        send_coef(make_coef(-32767, 1'b0));
        send_coef(make_coef(-32768, 1'b0));
        send_coef(make_coef(0, 1'b0));
        send_coef(make_coef(0, 1'b0));
        send_coef(make_coef(2, 1'b0));
        send_coef(make_coef(-2, 1'b0));
        send_coef(make_coef(0, 1'b0));
        // Trailing zeros at the block's end give one pair with run minus one.
        send_coef(make_coef(0, 1'b1));
        send_coef(make_coef(0, 1'b1));
        send_coef(make_coef(7, 1'b1));
        send_coef(make_coef(16384, 1'b0));
        send_coef(make_coef(-16384, 1'b0));
        send_coef(make_coef(0, 1'b0));
        send_coef(make_coef(-3, 1'b1));
        send_coef(make_coef(21845, 1'b0));
        send_coef(make_coef(-21846, 1'b0));
        send_coef(make_coef(-32768, 1'b1));
        drain_pairs();

        -> hold_start;
        run_blocks(650);
        drain_pairs();

        send_idle_pct = 53;
        recv_idle_pct <= 11;
        run_blocks(1300);
        drain_pairs();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        -> hold_start;
        run_blocks(1950);
        drain_pairs();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pairs_owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
